// File: rtl/vfa_pkg.sv
// ----------------------------------------------------------------------------
// vfa_pkg: shared types and constants of the three-component vector ALU
// Opcodes, internal value widths and the side-band records that travel with
// each transaction through the root and quotient pipelines.
// ----------------------------------------------------------------------------
package vfa_pkg;

  localparam int LANE_W = 32;
  localparam int VAL_W  = 68;
  localparam int ROOT_W = 33;
  localparam int DIV_QB = 34;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_ADD_S  = 4'd4,
    OP_SUB_S  = 4'd5,
    OP_MUL_S  = 4'd6,
    OP_DIV_S  = 4'd7,
    OP_S_SUB  = 4'd8,
    OP_S_DIV  = 4'd9,
    OP_NEG    = 4'd10,
    OP_NORM   = 4'd11,
    OP_NORM2D = 4'd12,
    OP_UNIT   = 4'd13,
    OP_CROSS  = 4'd14,
    OP_DOT    = 4'd15
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [2:0][LANE_W-1:0]  a;
    logic [2:0][LANE_W-1:0]  b;
    logic [LANE_W-1:0]       s;
    logic [2:0][VAL_W-1:0]   val;
    logic [VAL_W-1:0]        sval;
  } sq_side_t;

  typedef struct packed {
    logic                    scalar;
    logic [2:0]              use_div;
    logic                    dz;
    logic [2:0][VAL_W-1:0]   val;
    logic [VAL_W-1:0]        sval;
  } fin_side_t;

endpackage

// File: rtl/vfa_sqrt.sv
// ----------------------------------------------------------------------------
// vfa_sqrt: pipelined rounded square root
// One root bit per stage over a 64-bit radicand, then a rounding stage.
// A side-band word travels alongside with the valid bit.
// ----------------------------------------------------------------------------
module vfa_sqrt #(
  parameter int PW = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [2*vfa_pkg::LANE_W-1:0] in_sq,
  input  logic [PW-1:0]              in_side,
  output logic                       out_valid,
  output logic [vfa_pkg::ROOT_W-1:0] out_root,
  output logic [PW-1:0]              out_side
);

  localparam int NI = vfa_pkg::LANE_W;
  localparam int SW = 2 * NI;
  localparam int RW = NI + 4;

  logic          v_r    [NI];
  logic [RW-1:0] rem_r  [NI];
  logic [NI-1:0] root_r [NI];
  logic [SW-1:0] src_r  [NI];
  logic [PW-1:0] side_r [NI];

  logic                       vo_r;
  logic [vfa_pkg::ROOT_W-1:0] root_o_r;
  logic [PW-1:0]              side_o_r;
  logic                       inc;

  for (genvar k = 0; k < NI; k++) begin : g_st
    logic [RW-1:0] rem_in, remx, trial, rem_nxt;
    logic [NI-1:0] root_in, root_nxt;
    logic [SW-1:0] src_in;
    logic          v_in;
    logic [PW-1:0] side_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign src_in  = in_sq;
      assign v_in    = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign src_in  = src_r[k-1];
      assign v_in    = v_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign remx  = {rem_in[RW-3:0], src_in[SW-1 -: 2]};
    assign trial = {{(RW-NI-2){1'b0}}, root_in, 2'b01};

    always_comb begin
      if (remx >= trial) begin
        rem_nxt  = remx - trial;
        root_nxt = {root_in[NI-2:0], 1'b1};
      end else begin
        rem_nxt  = remx;
        root_nxt = {root_in[NI-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      src_r[k]  <= {src_in[SW-3:0], 2'b00};
      side_r[k] <= side_in;
    end
  end

  assign inc = rem_r[NI-1] > RW'(root_r[NI-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[NI-1];
    end
    root_o_r <= {1'b0, root_r[NI-1]} + vfa_pkg::ROOT_W'(inc);
    side_o_r <= side_r[NI-1];
  end

  assign out_valid = vo_r;
  assign out_root  = root_o_r;
  assign out_side  = side_o_r;

endmodule

// File: rtl/vfa_div.sv
// ----------------------------------------------------------------------------
// vfa_div: three-lane pipelined fixed-point divider
// Restoring division, one quotient bit per stage, rounded to nearest with
// ties away from zero; quotients out of reach are flagged and pushed wide.
// ----------------------------------------------------------------------------
module vfa_div #(
  parameter int FRAC_BITS = 16,
  parameter int PW        = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [vfa_pkg::LANE_W-1:0] in_un [3],
  input  logic [vfa_pkg::LANE_W-1:0] in_ud [3],
  input  logic [2:0]                 in_neg,
  input  logic [PW-1:0]              in_side,
  output logic                       out_valid,
  output logic [vfa_pkg::VAL_W-1:0]  out_val [3],
  output logic [PW-1:0]              out_side
);

  localparam int LW  = vfa_pkg::LANE_W;
  localparam int VW  = vfa_pkg::VAL_W;
  localparam int QB  = vfa_pkg::DIV_QB;
  localparam int NW  = LW + FRAC_BITS;
  localparam int NST = QB + 3;

  logic          v_r    [NST];
  logic [PW-1:0] side_r [NST];

  for (genvar k = 0; k < NST; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1];
      end
      side_r[k] <= (k == 0) ? in_side : side_r[(k == 0) ? 0 : k-1];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [NW-1:0]   num;
    logic [LW-1:0]   top;
    logic [LW-1:0]   rem_r [QB+1];
    logic [QB-1:0]   lo_r  [QB+1];
    logic [QB-1:0]   q_r   [QB+1];
    logic [LW-1:0]   ud_r  [QB+1];
    logic            neg_r [QB+1];
    logic            ovf_r [QB+1];
    logic [QB:0]     qr_r;
    logic            negr_r, ovfr_r;
    logic            rb;
    logic signed [VW-1:0] mag, val_r;

    assign num = {in_un[l], {FRAC_BITS{1'b0}}};
    assign top = LW'(num >> QB);

    always_ff @(posedge clk) begin
      rem_r[0] <= top;
      lo_r[0]  <= num[QB-1:0];
      q_r[0]   <= '0;
      ud_r[0]  <= in_ud[l];
      neg_r[0] <= in_neg[l];
      ovf_r[0] <= top >= in_ud[l];
    end

    for (genvar j = 1; j <= QB; j++) begin : g_it
      logic [LW:0]   remx;
      logic          ge;
      logic [LW-1:0] rem_nxt;

      assign remx    = {rem_r[j-1], lo_r[j-1][QB-1]};
      assign ge      = remx >= {1'b0, ud_r[j-1]};
      assign rem_nxt = ge ? LW'(remx - {1'b0, ud_r[j-1]}) : remx[LW-1:0];

      always_ff @(posedge clk) begin
        rem_r[j] <= rem_nxt;
        lo_r[j]  <= {lo_r[j-1][QB-2:0], 1'b0};
        q_r[j]   <= {q_r[j-1][QB-2:0], ge};
        ud_r[j]  <= ud_r[j-1];
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end

    assign rb  = {rem_r[QB], 1'b0} >= {1'b0, ud_r[QB]};
    assign mag = ovfr_r ? (VW'(1) << (QB + 1)) : VW'(qr_r);

    always_ff @(posedge clk) begin
      qr_r   <= {1'b0, q_r[QB]} + (QB+1)'(rb);
      negr_r <= neg_r[QB];
      ovfr_r <= ovf_r[QB];
      val_r  <= negr_r ? -mag : mag;
    end

    assign out_val[l] = val_r;
  end

  assign out_valid = v_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

// File: rtl/vector3_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu: three-component Q-format vector ALU
// Elementwise and vector-scalar arithmetic, negate, norms, unit vector,
// cross and dot product with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_* and raise start for one cycle per transaction; busy is always
//   low, so a transaction is taken at every edge where start is high.
//   The result appears on out_* for exactly one cycle with out_valid high.
//   Every opcode runs through the same fixed pipeline, so results leave
//   in order.
//   Throughput: one transaction per clock. Latency is set by the 32-stage
//   root pipeline feeding the 34-stage quotient pipeline (one bit per stage),
//   plus operand, multiply, combine, set-up, rounding and output stages.
//   The receiver cannot stall; results are presented once and not held.
//   Reset (rst_n low, synchronous) drops every transaction in flight and
//   clears out_valid; the data registers are not reset.
//   out_res_x/y/z are zero for norm and dot; out_res_scalar is zero for
//   vector results. out_saturated flags a clamp, out_div_zero a zero divisor.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_action,
  input  logic signed [31:0] in_first_x,
  input  logic signed [31:0] in_first_y,
  input  logic signed [31:0] in_first_z,
  input  logic signed [31:0] in_second_x,
  input  logic signed [31:0] in_second_y,
  input  logic signed [31:0] in_second_z,
  input  logic signed [31:0] in_scalar_in,
  output logic               out_valid,
  output logic signed [31:0] out_res_x,
  output logic signed [31:0] out_res_y,
  output logic signed [31:0] out_res_z,
  output logic signed [31:0] out_res_scalar,
  output logic               out_saturated,
  output logic               out_div_zero
);

  localparam int LW = vfa_pkg::LANE_W;
  localparam int VW = vfa_pkg::VAL_W;
  localparam int OB = (WORD_BITS < LW) ? WORD_BITS : LW;
  localparam logic signed [VW-1:0] OMAX = (VW'(1) << (OB - 1)) - VW'(1);
  localparam logic signed [VW-1:0] OMIN = -OMAX - VW'(1);
  localparam logic signed [VW-1:0] HALF = VW'(1) << (FRAC_BITS - 1);
  localparam int SQ_PW  = $bits(vfa_pkg::sq_side_t);
  localparam int FIN_PW = $bits(vfa_pkg::fin_side_t);

  function automatic logic signed [VW-1:0] rnd(input logic signed [VW-1:0] x);
    return (x + HALF) >>> FRAC_BITS;
  endfunction

  // operand capture
  logic                 v1_r;
  vfa_pkg::op_t         op1_r;
  logic signed [LW-1:0] a1_r [3];
  logic signed [LW-1:0] b1_r [3];
  logic signed [LW-1:0] s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    op1_r   <= vfa_pkg::op_t'(in_action);
    a1_r[0] <= in_first_x;
    a1_r[1] <= in_first_y;
    a1_r[2] <= in_first_z;
    b1_r[0] <= in_second_x;
    b1_r[1] <= in_second_y;
    b1_r[2] <= in_second_z;
    s1_r    <= in_scalar_in;
  end

  // multiply
  logic signed [LW-1:0]   ma [6];
  logic signed [LW-1:0]   mb [6];
  logic                   v2_r;
  vfa_pkg::op_t           op2_r;
  logic signed [LW-1:0]   a2_r [3];
  logic signed [LW-1:0]   b2_r [3];
  logic signed [LW-1:0]   s2_r;
  logic signed [2*LW-1:0] p2_r [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ma[k] = '0;
      mb[k] = '0;
    end
    unique case (op1_r) inside
      vfa_pkg::OP_MUL, vfa_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = a1_r[i];
          mb[i] = b1_r[i];
        end
      end
      vfa_pkg::OP_MUL_S: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = b1_r[i];
          mb[i] = s1_r;
        end
      end
      vfa_pkg::OP_NORM, vfa_pkg::OP_UNIT: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = b1_r[i];
          mb[i] = b1_r[i];
        end
      end
      vfa_pkg::OP_NORM2D: begin
        for (int i = 0; i < 2; i++) begin
          ma[i] = b1_r[i];
          mb[i] = b1_r[i];
        end
      end
      vfa_pkg::OP_CROSS: begin
        ma[0] = a1_r[1]; mb[0] = b1_r[2];
        ma[1] = a1_r[2]; mb[1] = b1_r[1];
        ma[2] = a1_r[2]; mb[2] = b1_r[0];
        ma[3] = a1_r[0]; mb[3] = b1_r[2];
        ma[4] = a1_r[0]; mb[4] = b1_r[1];
        ma[5] = a1_r[1]; mb[5] = b1_r[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    op2_r <= op1_r;
    a2_r  <= a1_r;
    b2_r  <= b1_r;
    s2_r  <= s1_r;
    for (int k = 0; k < 6; k++) begin
      p2_r[k] <= ma[k] * mb[k];
    end
  end

  // combine
  logic signed [VW-1:0] pv [6];
  logic signed [VW-1:0] av [3];
  logic signed [VW-1:0] bv [3];
  logic signed [VW-1:0] sv;
  logic signed [VW-1:0] val3 [3];
  logic signed [VW-1:0] sval3;
  logic [2*LW-1:0]      sq3;
  vfa_pkg::sq_side_t    side3;
  logic                 v3_r;
  vfa_pkg::sq_side_t    side3_r;
  logic [2*LW-1:0]      sq3_r;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pv[k] = VW'(p2_r[k]);
    end
    for (int i = 0; i < 3; i++) begin
      av[i]   = VW'(a2_r[i]);
      bv[i]   = VW'(b2_r[i]);
      val3[i] = '0;
    end
    sv    = VW'(s2_r);
    sval3 = '0;
    sq3   = '0;
    unique case (op2_r) inside
      vfa_pkg::OP_ADD:   for (int i = 0; i < 3; i++) val3[i] = av[i] + bv[i];
      vfa_pkg::OP_SUB:   for (int i = 0; i < 3; i++) val3[i] = av[i] - bv[i];
      vfa_pkg::OP_ADD_S: for (int i = 0; i < 3; i++) val3[i] = bv[i] + sv;
      vfa_pkg::OP_SUB_S: for (int i = 0; i < 3; i++) val3[i] = bv[i] - sv;
      vfa_pkg::OP_S_SUB: for (int i = 0; i < 3; i++) val3[i] = sv - bv[i];
      vfa_pkg::OP_NEG:   for (int i = 0; i < 3; i++) val3[i] = -bv[i];
      vfa_pkg::OP_MUL, vfa_pkg::OP_MUL_S: begin
        for (int i = 0; i < 3; i++) val3[i] = rnd(pv[i]);
      end
      vfa_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) val3[i] = rnd(pv[2*i] - pv[2*i+1]);
      end
      vfa_pkg::OP_UNIT: begin
        for (int i = 0; i < 3; i++) val3[i] = bv[i];
        sq3 = (2*LW)'(pv[0] + pv[1] + pv[2]);
      end
      vfa_pkg::OP_NORM, vfa_pkg::OP_NORM2D: begin
        sq3 = (2*LW)'(pv[0] + pv[1] + pv[2]);
      end
      vfa_pkg::OP_DOT: sval3 = rnd(pv[0] + pv[1] + pv[2]);
      default: begin
      end
    endcase
    side3.op = op2_r;
    for (int i = 0; i < 3; i++) begin
      side3.a[i]   = a2_r[i];
      side3.b[i]   = b2_r[i];
      side3.val[i] = val3[i];
    end
    side3.s    = s2_r;
    side3.sval = sval3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    side3_r <= side3;
    sq3_r   <= sq3;
  end

  // magnitude
  logic                       sq_v;
  logic [vfa_pkg::ROOT_W-1:0] sq_root;
  logic [SQ_PW-1:0]           sq_side_w;
  vfa_pkg::sq_side_t          sqo;

  vfa_sqrt #(
    .PW (SQ_PW)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_sq     (sq3_r),
    .in_side   (side3_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side_w)
  );

  assign sqo = vfa_pkg::sq_side_t'(sq_side_w);

  // divider set-up
  logic signed [LW-1:0] n4 [3];
  logic signed [LW-1:0] d4 [3];
  logic                 dop4 [3];
  logic                 mz;
  logic [LW-1:0]        un4 [3];
  logic [LW-1:0]        ud4 [3];
  logic [2:0]           neg4;
  vfa_pkg::fin_side_t   fin4;
  logic                 v4_r;
  logic [LW-1:0]        un4_r [3];
  logic [LW-1:0]        ud4_r [3];
  logic [2:0]           neg4_r;
  vfa_pkg::fin_side_t   fin4_r;

  assign mz = sq_root == '0;

  always_comb begin
    fin4.scalar  = (sqo.op == vfa_pkg::OP_NORM) || (sqo.op == vfa_pkg::OP_NORM2D) ||
                   (sqo.op == vfa_pkg::OP_DOT);
    fin4.dz      = 1'b0;
    fin4.use_div = '0;
    fin4.val     = sqo.val;
    fin4.sval    = ((sqo.op == vfa_pkg::OP_NORM) || (sqo.op == vfa_pkg::OP_NORM2D)) ?
                   VW'(sq_root) : sqo.sval;
    for (int i = 0; i < 3; i++) begin
      n4[i]   = '0;
      d4[i]   = '0;
      dop4[i] = 1'b0;
      unique case (sqo.op) inside
        vfa_pkg::OP_DIV: begin
          n4[i] = $signed(sqo.a[i]); d4[i] = $signed(sqo.b[i]); dop4[i] = 1'b1;
        end
        vfa_pkg::OP_DIV_S: begin
          n4[i] = $signed(sqo.b[i]); d4[i] = $signed(sqo.s); dop4[i] = 1'b1;
        end
        vfa_pkg::OP_S_DIV: begin
          n4[i] = $signed(sqo.s); d4[i] = $signed(sqo.b[i]); dop4[i] = 1'b1;
        end
        vfa_pkg::OP_UNIT: begin
          n4[i] = $signed(sqo.b[i]); dop4[i] = 1'b0;
        end
        default: begin
        end
      endcase
      un4[i]  = n4[i][LW-1] ? LW'(-n4[i]) : n4[i];
      ud4[i]  = d4[i][LW-1] ? LW'(-d4[i]) : d4[i];
      neg4[i] = n4[i][LW-1] ^ d4[i][LW-1];
      if (sqo.op == vfa_pkg::OP_UNIT) begin
        ud4[i]          = sq_root[LW-1:0];
        neg4[i]         = n4[i][LW-1];
        fin4.use_div[i] = !mz;
      end else if (dop4[i]) begin
        if (d4[i] == '0) begin
          fin4.dz     = 1'b1;
          fin4.val[i] = (n4[i] > 0) ? OMAX : ((n4[i] < 0) ? OMIN : '0);
        end else begin
          fin4.use_div[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= sq_v;
    end
    un4_r  <= un4;
    ud4_r  <= ud4;
    neg4_r <= neg4;
    fin4_r <= fin4;
  end

  // divide
  logic              dv_v;
  logic [VW-1:0]     dval [3];
  logic [FIN_PW-1:0] dside_w;

  vfa_div #(
    .FRAC_BITS (FRAC_BITS),
    .PW        (FIN_PW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_un     (un4_r),
    .in_ud     (ud4_r),
    .in_neg    (neg4_r),
    .in_side   (fin4_r),
    .out_valid (dv_v),
    .out_val   (dval),
    .out_side  (dside_w)
  );

  // clamp and present
  vfa_pkg::fin_side_t   fin5;
  logic signed [VW-1:0] x5 [3];
  logic signed [VW-1:0] c5 [3];
  logic [2:0]           sat5;
  logic signed [VW-1:0] xs5, cs5;
  logic                 ssat5;
  logic                 ov_r;
  logic signed [LW-1:0] rx_r, ry_r, rz_r, rs_r;
  logic                 sat_r, dz_r;

  assign fin5 = vfa_pkg::fin_side_t'(dside_w);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x5[i]   = fin5.use_div[i] ? $signed(dval[i]) : $signed(fin5.val[i]);
      sat5[i] = (x5[i] > OMAX) || (x5[i] < OMIN);
      c5[i]   = (x5[i] > OMAX) ? OMAX : ((x5[i] < OMIN) ? OMIN : x5[i]);
    end
    xs5   = $signed(fin5.sval);
    ssat5 = (xs5 > OMAX) || (xs5 < OMIN);
    cs5   = (xs5 > OMAX) ? OMAX : ((xs5 < OMIN) ? OMIN : xs5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= dv_v;
    end
    rx_r  <= fin5.scalar ? '0 : c5[0][LW-1:0];
    ry_r  <= fin5.scalar ? '0 : c5[1][LW-1:0];
    rz_r  <= fin5.scalar ? '0 : c5[2][LW-1:0];
    rs_r  <= fin5.scalar ? cs5[LW-1:0] : '0;
    sat_r <= fin5.scalar ? ssat5 : (|sat5);
    dz_r  <= fin5.dz;
  end

  assign busy           = 1'b0;
  assign out_valid      = ov_r;
  assign out_res_x      = rx_r;
  assign out_res_y      = ry_r;
  assign out_res_z      = rz_r;
  assign out_res_scalar = rs_r;
  assign out_saturated  = sat_r;
  assign out_div_zero   = dz_r;

endmodule
